// ===== sv/aae_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aae_pkg: shared types and constants for the axis-angle to Euler converter
// Holds the controller states, the datapath commands, the CORDIC arctangent
// table and the fixed-point constants; every module of the block imports it.
// ----------------------------------------------------------------------------
package aae_pkg;

  // Default parameter values for the top level.
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_ANGLE_BITS   = 16;

  // Width of the signed Q24 algebra registers.
  localparam int DW = 32;
  // Width of the CORDIC x and y registers.
  localparam int CX = 34;
  // Length of the arctangent table.
  localparam int TAB_LEN = 24;

  localparam logic [16:0] LIMIT_RESET = 17'd65535;
  localparam logic signed [DW-1:0] ONE_Q24 = 32'sh0100_0000;
  localparam logic signed [CX-1:0] GAIN_Q30 = 34'sd652032875;

  // Arctangent of 2^-i with a full turn equal to 2^32.
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Table entry rounded to nearest at a coarser angle resolution.
  function automatic logic [33:0] atan_entry(input int idx, input int sh);
    logic [33:0] v;
    v = {2'b00, ATAN_TAB[idx]};
    if (sh > 0) begin
      v = (v + (34'd1 << (sh - 1))) >> sh;
    end
    return v;
  endfunction

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SC1, OP_SC2, OP_T, OP_XY, OP_TBT, OP_ZS, OP_TV,
    OP_GXS, OP_GATN, OP_TC2, OP_SQRT, OP_PATN, OP_YS, OP_XZ, OP_SUB, OP_YY,
    OP_ZZ, OP_ADDZ, OP_DEN, OP_YATN, OP_XS, OP_YZ, OP_XX, OP_RATN, OP_PUSH
  } op_t;

  // Controller states, one per step of the conversion.
  typedef enum logic [5:0] {
    ST_IDLE, ST_SC1, ST_SC2, ST_T, ST_XY, ST_XYT, ST_ZS, ST_TV, ST_BRANCH,
    ST_GXS, ST_GATN, ST_TC2, ST_SQRT, ST_PATN, ST_YS, ST_XZ, ST_XZT, ST_YSUB,
    ST_YY, ST_ZZ, ST_YADD, ST_YYT, ST_YDEN, ST_YATN, ST_XS, ST_YZ, ST_YZT,
    ST_RSUB, ST_XX, ST_RADD, ST_XXT, ST_RDEN, ST_RATN, ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic gimbal;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/aae_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aae_cordic: shared iterative CORDIC unit
// Rotation mode yields cosine and sine of an angle, vectoring mode yields
// atan2 of a vector. One micro-rotation is done per clock cycle.
// ----------------------------------------------------------------------------
module aae_cordic import aae_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          vec_mode,
  input  wire logic signed [CX-1:0]          x_in,
  input  wire logic signed [CX-1:0]          y_in,
  input  wire logic signed [ANGLE_BITS+9:0]  z_in,
  output logic                               done,
  output logic signed [CX-1:0]               x_out,
  output logic signed [CX-1:0]               y_out,
  output logic signed [ANGLE_BITS+9:0]       z_out
);

  localparam int AW  = ANGLE_BITS + 10;
  localparam int CW  = $clog2(CORDIC_STEPS);
  localparam int TSH = 24 - ANGLE_BITS;
  localparam logic signed [AW-1:0] PI_A =
    {{(AW-ANGLE_BITS-8){1'b0}}, 1'b1, {(ANGLE_BITS+7){1'b0}}};
  localparam logic signed [AW-1:0] HALF_A =
    {{(AW-ANGLE_BITS-7){1'b0}}, 1'b1, {(ANGLE_BITS+6){1'b0}}};

  logic signed [CX-1:0] x_r, y_r;
  logic signed [AW-1:0] z_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r, neg_r, vec_r;

  logic [33:0]          ent_full;
  logic signed [AW-1:0] ent;
  logic signed [CX-1:0] dx, dy;
  logic                 up;

  // One micro-rotation from the current registers.
  always_comb begin
    ent_full = atan_entry(int'(cnt_r), TSH);
    ent      = signed'(ent_full[AW-1:0]);
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    up       = vec_r ? (y_r < 0) : (z_r >= 0);
  end

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= !(vec_mode && x_in == 0 && y_in == 0);
        done_r <= vec_mode && x_in == 0 && y_in == 0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Vector and angle registers.
  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec_mode;
      if (vec_mode) begin
        neg_r <= 1'b0;
        if (x_in < 0) begin
          x_r <= -x_in;
          y_r <= -y_in;
          z_r <= (y_in >= 0) ? PI_A : -PI_A;
        end else begin
          x_r <= x_in;
          y_r <= y_in;
          z_r <= '0;
        end
      end else begin
        x_r <= GAIN_Q30;
        y_r <= '0;
        if (z_in > HALF_A) begin
          z_r   <= z_in - PI_A;
          neg_r <= 1'b1;
        end else if (z_in < -HALF_A) begin
          z_r   <= z_in + PI_A;
          neg_r <= 1'b1;
        end else begin
          z_r   <= z_in;
          neg_r <= 1'b0;
        end
      end
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ent;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ent;
      end
    end
  end

  assign done  = done_r;
  assign x_out = neg_r ? -x_r : x_r;
  assign y_out = neg_r ? -y_r : y_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

// ===== sv/aae_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aae_isqrt: iterative integer square root
// Digit-by-digit square root of a 49-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module aae_isqrt import aae_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [48:0] rad,
  output logic             done,
  output logic [24:0]      root
);

  logic [49:0] v_r, res_r, bit_r;
  logic        busy_r, done_r;
  logic [49:0] trial;

  assign trial = res_r + bit_r;

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 50'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Remainder and partial root.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {1'b0, rad};
      res_r <= '0;
      bit_r <= 50'd1 << 48;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[24:0];

endmodule
`default_nettype wire

// ===== sv/aae_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aae_datapath: registers, shared multiplier and iterative units
// Executes one operation per command from the controller and holds the
// limit register and the output result registers.
// ----------------------------------------------------------------------------
module aae_datapath import aae_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic signed [17:0] axis_x,
  input  wire logic signed [17:0] axis_y,
  input  wire logic signed [17:0] axis_z,
  input  wire logic signed [15:0] rot_angle,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_limit,
  output logic signed [15:0]      yaw_out,
  output logic signed [15:0]      pitch_out,
  output logic signed [15:0]      roll_out
);

  localparam int AW = ANGLE_BITS + 10;
  localparam int OSH = ANGLE_BITS - 8;
  localparam logic signed [AW+1:0] HALF_PI =
    {{(AW-ANGLE_BITS-5){1'b0}}, 1'b1, {(ANGLE_BITS+6){1'b0}}};

  // Round half up to a 16-bit binary angle.
  function automatic logic signed [15:0] to_out(input logic signed [AW+1:0] v);
    logic signed [AW+1:0] r;
    r = (v + (AW+2)'(1 << (OSH - 1))) >>> OSH;
    return r[15:0];
  endfunction

  logic signed [DW-1:0] x_r, y_r, z_r, s_r, c_r, sh_r, ch_r, t_r;
  logic signed [DW-1:0] ta_r, tb_r, zz_r, tc_r;
  logic signed [15:0]   ra_r;
  logic                 neg_r, gim_r;
  logic [48:0]          rad_r;
  logic signed [15:0]   yaw_r, pitch_r, roll_r;
  logic signed [15:0]   oyaw_r, opitch_r, oroll_r;
  logic [16:0]          lim_r;

  logic signed [DW-1:0] mul_a, mul_b, mq;
  logic signed [63:0]   prod;
  logic signed [DW-1:0] tv, mag;
  logic signed [AW-1:0] ra_ext;
  logic                 cor_start, cor_vec, cor_done, sq_done;
  logic signed [CX-1:0] cor_xi, cor_yi, cor_xo, cor_yo, cxs, cys;
  logic signed [AW-1:0] cor_zi, cor_zo;
  logic signed [AW+1:0] zx, gyaw;
  logic [24:0]          root;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = x_r;
    mul_b = y_r;
    case (cmd.op)
      OP_XY:   begin mul_a = x_r;  mul_b = y_r;  end
      OP_TBT:  begin mul_a = tb_r; mul_b = t_r;  end
      OP_ZS:   begin mul_a = z_r;  mul_b = s_r;  end
      OP_GXS:  begin mul_a = x_r;  mul_b = sh_r; end
      OP_TC2:  begin mul_a = tc_r; mul_b = tc_r; end
      OP_YS:   begin mul_a = y_r;  mul_b = s_r;  end
      OP_XZ:   begin mul_a = x_r;  mul_b = z_r;  end
      OP_YY:   begin mul_a = y_r;  mul_b = y_r;  end
      OP_ZZ:   begin mul_a = z_r;  mul_b = z_r;  end
      OP_XS:   begin mul_a = x_r;  mul_b = s_r;  end
      OP_YZ:   begin mul_a = y_r;  mul_b = z_r;  end
      OP_XX:   begin mul_a = x_r;  mul_b = x_r;  end
      default: begin mul_a = x_r;  mul_b = y_r;  end
    endcase
    prod = mul_a * mul_b;
    mq   = prod[55:24];
    tv   = ta_r + tb_r;
    mag  = (tv < 0) ? -tv : tv;
  end

  // CORDIC request for the current operation.
  always_comb begin
    ra_ext    = {{(AW-16){ra_r[15]}}, ra_r};
    cor_start = 1'b0;
    cor_vec   = 1'b1;
    cor_xi    = {{(CX-DW){tb_r[DW-1]}}, tb_r};
    cor_yi    = {{(CX-DW){ta_r[DW-1]}}, ta_r};
    cor_zi    = ra_ext <<< (ANGLE_BITS - 8);
    case (cmd.op)
      OP_SC1: begin
        cor_start = cmd.start;
        cor_vec   = 1'b0;
      end
      OP_SC2: begin
        cor_start = cmd.start;
        cor_vec   = 1'b0;
        cor_zi    = ra_ext <<< (ANGLE_BITS - 9);
      end
      OP_GATN: begin
        cor_start = cmd.start;
        cor_xi    = {{(CX-DW){ch_r[DW-1]}}, ch_r};
      end
      OP_PATN: begin
        cor_start = cmd.start;
        cor_xi    = CX'(root);
        cor_yi    = {{(CX-DW){tc_r[DW-1]}}, tc_r};
      end
      OP_YATN, OP_RATN: begin
        cor_start = cmd.start;
      end
      default: begin
        cor_start = 1'b0;
      end
    endcase
    cxs  = cor_xo >>> 6;
    cys  = cor_yo >>> 6;
    zx   = {{2{cor_zo[AW-1]}}, cor_zo};
    gyaw = zx <<< 1;
  end

  aae_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cor_start),
    .vec_mode (cor_vec),
    .x_in     (cor_xi),
    .y_in     (cor_yi),
    .z_in     (cor_zi),
    .done     (cor_done),
    .x_out    (cor_xo),
    .y_out    (cor_yo),
    .z_out    (cor_zo)
  );

  aae_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && cmd.op == OP_SQRT),
    .rad   (rad_r),
    .done  (sq_done),
    .root  (root)
  );

  // Limit register, written over the configuration channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_limit;
    end
  end

  // Operation execution.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r  <= {{(DW-26){axis_x[17]}}, axis_x, 8'd0};
        y_r  <= {{(DW-26){axis_y[17]}}, axis_y, 8'd0};
        z_r  <= {{(DW-26){axis_z[17]}}, axis_z, 8'd0};
        ra_r <= rot_angle;
      end
      OP_SC1: begin
        if (cor_done) begin
          c_r <= cxs[DW-1:0];
          s_r <= cys[DW-1:0];
        end
      end
      OP_SC2: begin
        if (cor_done) begin
          ch_r <= cxs[DW-1:0];
          sh_r <= cys[DW-1:0];
        end
      end
      OP_T:   t_r  <= ONE_Q24 - c_r;
      OP_XY, OP_TBT, OP_XZ, OP_YY, OP_YZ, OP_XX: tb_r <= mq;
      OP_ZS, OP_GXS, OP_YS, OP_XS: ta_r <= mq;
      OP_ZZ:  zz_r <= mq;
      OP_SUB: ta_r <= ta_r - tb_r;
      OP_ADDZ: tb_r <= tb_r + zz_r;
      OP_DEN: tb_r <= ONE_Q24 - tb_r;
      OP_TV: begin
        neg_r <= tv < 0;
        gim_r <= mag > DW'({lim_r, 8'd0});
        if (tv > ONE_Q24) begin
          tc_r <= ONE_Q24;
        end else if (tv < -ONE_Q24) begin
          tc_r <= -ONE_Q24;
        end else begin
          tc_r <= tv;
        end
      end
      OP_TC2: rad_r <= 49'h1_0000_0000_0000 - prod[48:0];
      OP_GATN: begin
        if (cor_done) begin
          yaw_r   <= to_out(neg_r ? -gyaw : gyaw);
          pitch_r <= to_out(neg_r ? -HALF_PI : HALF_PI);
          roll_r  <= '0;
        end
      end
      OP_PATN: if (cor_done) pitch_r <= to_out(zx);
      OP_YATN: if (cor_done) yaw_r <= to_out(zx);
      OP_RATN: if (cor_done) roll_r <= to_out(zx);
      OP_PUSH: begin
        oyaw_r   <= yaw_r;
        opitch_r <= pitch_r;
        oroll_r  <= roll_r;
      end
      default: begin
        ta_r <= ta_r;
      end
    endcase
  end

  assign sts.cordic_done = cor_done;
  assign sts.sqrt_done   = sq_done;
  assign sts.gimbal      = gim_r;
  assign yaw_out         = oyaw_r;
  assign pitch_out       = opitch_r;
  assign roll_out        = oroll_r;

endmodule
`default_nettype wire

// ===== sv/aae_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aae_ctrl: conversion sequencer
// Steps the datapath through the conversion, one operation per state, and
// runs the input and output handshakes.
// ----------------------------------------------------------------------------
module aae_ctrl import aae_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   first_r, out_valid_r, out_valid_nxt;
  logic   push;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SC1;
      ST_SC1:    if (sts.cordic_done) state_nxt = ST_SC2;
      ST_SC2:    if (sts.cordic_done) state_nxt = ST_T;
      ST_T:      state_nxt = ST_XY;
      ST_XY:     state_nxt = ST_XYT;
      ST_XYT:    state_nxt = ST_ZS;
      ST_ZS:     state_nxt = ST_TV;
      ST_TV:     state_nxt = ST_BRANCH;
      ST_BRANCH: state_nxt = sts.gimbal ? ST_GXS : ST_TC2;
      ST_GXS:    state_nxt = ST_GATN;
      ST_GATN:   if (sts.cordic_done) state_nxt = ST_DONE;
      ST_TC2:    state_nxt = ST_SQRT;
      ST_SQRT:   if (sts.sqrt_done) state_nxt = ST_PATN;
      ST_PATN:   if (sts.cordic_done) state_nxt = ST_YS;
      ST_YS:     state_nxt = ST_XZ;
      ST_XZ:     state_nxt = ST_XZT;
      ST_XZT:    state_nxt = ST_YSUB;
      ST_YSUB:   state_nxt = ST_YY;
      ST_YY:     state_nxt = ST_ZZ;
      ST_ZZ:     state_nxt = ST_YADD;
      ST_YADD:   state_nxt = ST_YYT;
      ST_YYT:    state_nxt = ST_YDEN;
      ST_YDEN:   state_nxt = ST_YATN;
      ST_YATN:   if (sts.cordic_done) state_nxt = ST_XS;
      ST_XS:     state_nxt = ST_YZ;
      ST_YZ:     state_nxt = ST_YZT;
      ST_YZT:    state_nxt = ST_RSUB;
      ST_RSUB:   state_nxt = ST_XX;
      ST_XX:     state_nxt = ST_RADD;
      ST_RADD:   state_nxt = ST_XXT;
      ST_XXT:    state_nxt = ST_RDEN;
      ST_RDEN:   state_nxt = ST_RATN;
      ST_RATN:   if (sts.cordic_done) state_nxt = ST_DONE;
      ST_DONE:   if (push) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath command for each state.
  always_comb begin
    push      = !out_valid_r || out_tready;
    cmd.start = first_r;
    in_tready = state_r == ST_IDLE;
    case (state_r)
      ST_IDLE:  cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      ST_SC1:   cmd.op = OP_SC1;
      ST_SC2:   cmd.op = OP_SC2;
      ST_T:     cmd.op = OP_T;
      ST_XY:    cmd.op = OP_XY;
      ST_XYT, ST_XZT, ST_YYT, ST_YZT, ST_XXT: cmd.op = OP_TBT;
      ST_ZS:    cmd.op = OP_ZS;
      ST_TV:    cmd.op = OP_TV;
      ST_GXS:   cmd.op = OP_GXS;
      ST_GATN:  cmd.op = OP_GATN;
      ST_TC2:   cmd.op = OP_TC2;
      ST_SQRT:  cmd.op = OP_SQRT;
      ST_PATN:  cmd.op = OP_PATN;
      ST_YS:    cmd.op = OP_YS;
      ST_XZ:    cmd.op = OP_XZ;
      ST_YSUB, ST_RSUB: cmd.op = OP_SUB;
      ST_YY:    cmd.op = OP_YY;
      ST_ZZ:    cmd.op = OP_ZZ;
      ST_YADD, ST_RADD: cmd.op = OP_ADDZ;
      ST_YDEN, ST_RDEN: cmd.op = OP_DEN;
      ST_YATN:  cmd.op = OP_YATN;
      ST_XS:    cmd.op = OP_XS;
      ST_YZ:    cmd.op = OP_YZ;
      ST_XX:    cmd.op = OP_XX;
      ST_RATN:  cmd.op = OP_RATN;
      ST_DONE:  cmd.op = push ? OP_PUSH : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // Output valid flag: set on a push, cleared when the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_DONE && push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= state_nxt != state_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/axis_angle_to_euler_angles_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_to_euler_angles_top: axis-angle to yaw, pitch and roll
// Converts a unit rotation axis and a rotation angle into Euler angles.
//
// The input stream carries one axis and angle per transfer; the output stream
// returns one yaw, pitch and roll triple per input. A separate write channel
// loads the singularity limit (unsigned Q1.16) and is always ready.
// One item is converted at a time. Two rotation passes of the shared CORDIC
// unit and three multiplies, then either one more multiply and one vectoring
// pass (gimbal lock) or one more multiply, a square root and three vectoring
// passes with further multiplies between them.
// The result sits in an output register, so a stalled receiver holds
// the block only when a second result is finished before the first is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
// pending result and sets the limit to 65535.
// ----------------------------------------------------------------------------
module axis_angle_to_euler_angles_top import aae_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // axis_x[17:0], axis_y[35:18], axis_z[53:36], rot_angle[69:54], zero pad
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // yaw_out[15:0], pitch_out[31:16], roll_out[47:32]
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data
);

  cmd_t               cmd;
  sts_t               sts;
  logic signed [15:0] yaw, pitch, roll;

  aae_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aae_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .axis_x    (in_tdata[17:0]),
    .axis_y    (in_tdata[35:18]),
    .axis_z    (in_tdata[53:36]),
    .rot_angle (in_tdata[69:54]),
    .cfg_we    (cfg_valid),
    .cfg_limit (cfg_data),
    .yaw_out   (yaw),
    .pitch_out (pitch),
    .roll_out  (roll)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {roll, pitch, yaw};

endmodule
`default_nettype wire
